/* rtl/core/sdsq_pkg.sv */
// Package for the SD card SPI-mode sequencer: opcodes, phases, steps and codes.
// No dependencies; used by every module in rtl/core but the checker.
package sdsq_pkg;

  localparam int unsigned BlockBytes = 512;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_INIT  = 2'd1,
    OP_READ  = 2'd2,
    OP_OTHER = 2'd3
  } opcode_e;

  typedef enum logic [11:0] {
    PH_IDLE     = 12'b0000_0000_0001,
    PH_WAKE     = 12'b0000_0000_0010,
    PH_DESEL    = 12'b0000_0000_0100,
    PH_READY    = 12'b0000_0000_1000,
    PH_FAILDES  = 12'b0000_0001_0000,
    PH_FRAME    = 12'b0000_0010_0000,
    PH_RESP     = 12'b0000_0100_0000,
    PH_TRAIL    = 12'b0000_1000_0000,
    PH_TOKEN    = 12'b0001_0000_0000,
    PH_DATA     = 12'b0010_0000_0000,
    PH_CRC      = 12'b0100_0000_0000,
    PH_FINAL    = 12'b1000_0000_0000
  } phase_e;

  typedef enum logic [3:0] {
    ST_CMD0, ST_CMD8, ST_V2_55, ST_V2_41, ST_CMD58, ST_PR_55, ST_PR_41,
    ST_V1_55, ST_V1_41, ST_MMC, ST_CMD16, ST_RD, ST_STOP
  } step_e;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_MMC  = 3'd1;
  localparam logic [2:0] KIND_SD1  = 3'd2;
  localparam logic [2:0] KIND_SD2  = 3'd3;
  localparam logic [2:0] KIND_HC   = 3'd4;
  localparam logic [2:0] KIND_ERR  = 3'd5;

  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_BUSY  = 3'd1;
  localparam logic [2:0] STAT_REJ   = 3'd2;
  localparam logic [2:0] STAT_TOKEN = 3'd3;
  localparam logic [2:0] STAT_NOCARD = 3'd4;

  localparam logic [2:0] REG_READY_TO = 3'd0;
  localparam logic [2:0] REG_TOKEN_TO = 3'd1;
  localparam logic [2:0] REG_RESP_RT  = 3'd2;
  localparam logic [2:0] REG_IDLE_RT  = 3'd3;
  localparam logic [2:0] REG_OPC_RT   = 3'd4;

  localparam logic [7:0] BYTE_FF    = 8'hFF;
  localparam logic [7:0] TOKEN_BYTE = 8'hFE;

  typedef struct packed {
    opcode_e     op;
    logic [7:0]  rx;
    logic [31:0] sector;
    logic [7:0]  count;
  } item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       select_low;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       block_last;
    logic       done_res;
    logic [2:0] status;
    logic [2:0] card_kind;
    logic [7:0] last_response;
  } result_t;

endpackage

/* rtl/core/sd_spi_init_and_read_sequencer.sv */
// SD card SPI-mode sequencer. Each input beat (a received byte, or a start of init or
// read) yields exactly one result beat with the next byte to exchange, chip select and
// any sector data byte. One beat per clock is sustained when not stalled: the engine does
// a single state update per beat, fed by a two-entry input queue and drained through one
// output register. Top level; depends on sdsq_pkg, sdsq_front and sdsq_engine.
module sd_spi_init_and_read_sequencer #(
  parameter int unsigned WAKE_BYTES = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // opcode, rx_byte, sector, sector_count, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // tx_byte, tx_valid, select_low, data_byte,
                                     // data_valid, done_res, status, card_kind,
                                     // last_response, zero pad
  output logic        m_axis_tlast   // block_last
);
  import sdsq_pkg::*;

  item_t   q_item;
  logic    q_valid, q_ready;
  result_t res;

  sdsq_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata[49:0]),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  sdsq_engine #(.WakeBytes(WAKE_BYTES)) u_engine (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_res_o(res)
  );

  assign m_axis_tdata = {6'd0, res.last_response, res.card_kind, res.status,
                         res.done_res, res.data_valid, res.data_byte,
                         res.select_low, res.tx_valid, res.tx_byte};
  assign m_axis_tlast = res.block_last;
endmodule

/* rtl/core/sdsq_front.sv */
// Input side of the sequencer: takes item beats and folds opcode three into a byte beat.
// Depends on sdsq_pkg.
module sdsq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [49:0]     in_data_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output sdsq_pkg::item_t q_item_o
);
  import sdsq_pkg::*;

  item_t cls;
  always_comb begin
    cls.op     = (in_data_i[1:0] == OP_OTHER) ? OP_BYTE : opcode_e'(in_data_i[1:0]);
    cls.rx     = in_data_i[9:2];
    cls.sector = in_data_i[41:10];
    cls.count  = in_data_i[49:42];
  end

  // Two-entry queue toward the sequencing engine.
  item_t     mem_q [2];
  logic      wr_q, rd_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* rtl/core/sdsq_engine.sv */
// Command sequencing engine: one state update per queued item, registered result.
// Depends on sdsq_pkg.
module sdsq_engine #(
  parameter int unsigned WakeBytes = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [23:0]      cfg_data_i,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  sdsq_pkg::item_t  q_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sdsq_pkg::result_t out_res_o
);
  import sdsq_pkg::*;

  logic [23:0] ready_to_q;
  logic [15:0] token_to_q, opc_rt_q;
  logic [7:0]  resp_rt_q, idle_rt_q;

  phase_e      phase_q, phase_d;
  step_e       step_q, step_d;
  logic [23:0] poll_q, poll_d;
  logic [15:0] retry_q, retry_d;
  logic [9:0]  idx_q, idx_d;
  logic [5:0]  cmd_q, cmd_d;
  logic [31:0] arg_q, arg_d, trail_q, trail_d;
  logic [7:0]  left_q, left_d, resp_q, resp_d;
  logic [2:0]  kind_q, kind_d, pend_q, pend_d;
  logic        busy_q, busy_d;

  result_t res_q, res_d;
  logic    ov_q;

  logic take;
  assign q_ready_o   = !ov_q || out_ready_i;
  assign take        = q_valid_i && q_ready_o;
  assign out_valid_o = ov_q;
  assign out_res_o   = res_q;

  logic [23:0] ready_lim;
  logic [15:0] token_lim;
  assign ready_lim = (ready_to_q == '0) ? 24'd1 : ready_to_q;
  assign token_lim = (token_to_q == '0) ? 16'd1 : token_to_q;

  always_comb begin
    item_t  it;
    logic   done;
    logic [7:0] r1;
    logic   cdone;
    logic [31:0] tr;
    it = q_item_i;
    phase_d = phase_q; step_d = step_q; poll_d = poll_q; retry_d = retry_q;
    idx_d = idx_q; cmd_d = cmd_q; arg_d = arg_q; trail_d = trail_q;
    left_d = left_q; resp_d = resp_q; kind_d = kind_q; pend_d = pend_q;
    busy_d = busy_q; done = 1'b0; r1 = it.rx; cdone = 1'b0; tr = '0;
    res_d = '0;

    unique case (it.op)
      OP_INIT: begin
        kind_d = KIND_NONE; busy_d = 1'b0; phase_d = PH_WAKE; idx_d = '0;
      end
      OP_READ: begin
        if (kind_q == KIND_NONE || kind_q >= KIND_ERR) begin
          phase_d = PH_IDLE; done = 1'b1; pend_d = STAT_NOCARD;
        end else begin
          left_d = (it.count == '0) ? 8'd1 : it.count;
          pend_d = STAT_OK; busy_d = 1'b0;
          step_d = ST_RD; phase_d = PH_DESEL;
          cmd_d  = (left_d == 8'd1) ? 6'd17 : 6'd18;
          arg_d  = (kind_q == KIND_HC) ? it.sector : {it.sector[22:0], 9'd0};
        end
      end
      default: begin
        unique case (phase_q)
          PH_WAKE: begin
            idx_d = idx_q + 10'd1;
            if (idx_d >= 10'(WakeBytes)) begin
              retry_d = {8'd0, idle_rt_q};
              step_d = ST_CMD0; cmd_d = 6'd0; arg_d = '0; phase_d = PH_DESEL;
            end
          end
          PH_DESEL: begin phase_d = PH_READY; poll_d = '0; end
          PH_READY: begin
            if (it.rx == BYTE_FF) begin
              phase_d = PH_FRAME; idx_d = '0;
            end else begin
              poll_d = poll_q + 24'd1;
              if (poll_d >= ready_lim) phase_d = PH_FAILDES;
            end
          end
          PH_FAILDES: begin busy_d = 1'b1; r1 = BYTE_FF; cdone = 1'b1; end
          PH_FRAME: begin
            idx_d = idx_q + 10'd1;
            if (idx_d >= ((cmd_q == 6'd12) ? 10'd7 : 10'd6)) begin
              phase_d = PH_RESP; poll_d = '0;
            end
          end
          PH_RESP: begin
            if (!it.rx[7] || poll_q >= {16'd0, resp_rt_q}) begin
              busy_d = 1'b0; cdone = 1'b1;
            end else begin
              poll_d = poll_q + 24'd1;
            end
          end
          PH_TRAIL: begin
            tr = {trail_q[23:0], it.rx};
            trail_d = tr;
            idx_d = idx_q + 10'd1;
            if (idx_d >= 10'd4) begin
              if (step_q == ST_CMD8) begin
                if (tr[15:8] == 8'h01 && tr[7:0] == 8'hAA) begin
                  retry_d = opc_rt_q;
                  step_d = ST_V2_55; cmd_d = 6'd55; arg_d = '0; phase_d = PH_DESEL;
                end else begin
                  phase_d = PH_FINAL;
                  pend_d = busy_d ? STAT_BUSY : STAT_NOCARD;
                end
              end else begin
                kind_d = tr[30] ? KIND_HC : KIND_SD2;
                phase_d = PH_FINAL; pend_d = STAT_OK;
              end
            end
          end
          PH_TOKEN: begin
            if (it.rx == TOKEN_BYTE) begin
              phase_d = PH_DATA; idx_d = '0;
            end else begin
              poll_d = poll_q + 24'd1;
              if (poll_d[15:0] >= token_lim || poll_d[23:16] != '0) begin
                pend_d = STAT_TOKEN;
                if (cmd_q == 6'd18) begin
                  step_d = ST_STOP; cmd_d = 6'd12; arg_d = '0; phase_d = PH_DESEL;
                end else phase_d = PH_FINAL;
              end
            end
          end
          PH_DATA: begin
            res_d.data_byte = it.rx; res_d.data_valid = 1'b1;
            if (idx_q == 10'(BlockBytes - 1)) begin
              res_d.block_last = 1'b1; phase_d = PH_CRC; idx_d = '0;
            end else idx_d = idx_q + 10'd1;
          end
          PH_CRC: begin
            idx_d = idx_q + 10'd1;
            if (idx_d >= 10'd2) begin
              left_d = left_q - 8'd1;
              if (cmd_q == 6'd18 && left_d != '0) begin
                phase_d = PH_TOKEN; poll_d = '0;
              end else if (cmd_q == 6'd18) begin
                step_d = ST_STOP; cmd_d = 6'd12; arg_d = '0; phase_d = PH_DESEL;
              end else phase_d = PH_FINAL;
            end
          end
          PH_FINAL: begin phase_d = PH_IDLE; done = 1'b1; end
          default: phase_d = PH_IDLE;
        endcase

        // Response handling for a finished command.
        if (cdone) begin
          logic fin;
          fin = 1'b0;
          resp_d = r1;
          unique case (step_q)
            ST_CMD0: begin
              if (r1 == 8'h01) begin
                step_d = ST_CMD8; cmd_d = 6'd8; arg_d = 32'h1AA; phase_d = PH_DESEL;
              end else if (retry_q == '0) fin = 1'b1;
              else begin
                retry_d = retry_q - 16'd1;
                step_d = ST_CMD0; cmd_d = 6'd0; arg_d = '0; phase_d = PH_DESEL;
              end
            end
            ST_CMD8: begin
              if (r1 == 8'h01) begin
                phase_d = PH_TRAIL; idx_d = '0; trail_d = '0;
              end else begin
                step_d = ST_PR_55; cmd_d = 6'd55; arg_d = '0; phase_d = PH_DESEL;
              end
            end
            ST_V2_55: begin
              step_d = ST_V2_41; cmd_d = 6'd41; arg_d = 32'h4000_0000; phase_d = PH_DESEL;
            end
            ST_V2_41: begin
              if (r1 == '0) begin
                step_d = ST_CMD58; cmd_d = 6'd58; arg_d = '0; phase_d = PH_DESEL;
              end else if (retry_q == '0) fin = 1'b1;
              else begin
                retry_d = retry_q - 16'd1;
                step_d = ST_V2_55; cmd_d = 6'd55; arg_d = '0; phase_d = PH_DESEL;
              end
            end
            ST_CMD58: begin
              if (r1 == '0) begin
                phase_d = PH_TRAIL; idx_d = '0; trail_d = '0;
              end else fin = 1'b1;
            end
            ST_PR_55: begin
              step_d = ST_PR_41; cmd_d = 6'd41; arg_d = '0; phase_d = PH_DESEL;
            end
            ST_PR_41: begin
              retry_d = opc_rt_q; arg_d = '0; phase_d = PH_DESEL;
              if (r1 <= 8'd1) begin
                kind_d = KIND_SD1; step_d = ST_V1_55; cmd_d = 6'd55;
              end else begin
                kind_d = KIND_MMC; step_d = ST_MMC; cmd_d = 6'd1;
              end
            end
            ST_V1_55: begin
              step_d = ST_V1_41; cmd_d = 6'd41; arg_d = '0; phase_d = PH_DESEL;
            end
            ST_V1_41, ST_MMC: begin
              if (r1 == '0) begin
                step_d = ST_CMD16; cmd_d = 6'd16; arg_d = 32'(BlockBytes);
                phase_d = PH_DESEL;
              end else if (retry_q == '0) begin
                kind_d = KIND_ERR; fin = 1'b1;
              end else begin
                retry_d = retry_q - 16'd1; arg_d = '0; phase_d = PH_DESEL;
                step_d = (step_q == ST_MMC) ? ST_MMC : ST_V1_55;
                cmd_d  = (step_q == ST_MMC) ? 6'd1 : 6'd55;
              end
            end
            ST_CMD16: begin
              if (r1 != '0) kind_d = KIND_ERR;
              fin = 1'b1;
            end
            ST_RD: begin
              if (r1 != '0) begin
                pend_d = busy_d ? STAT_BUSY : STAT_REJ; phase_d = PH_FINAL;
              end else begin
                phase_d = PH_TOKEN; poll_d = '0;
              end
            end
            default: phase_d = PH_FINAL;
          endcase
          if (fin) begin
            phase_d = PH_FINAL;
            if (kind_d >= KIND_MMC && kind_d <= KIND_HC) pend_d = STAT_OK;
            else if (kind_d == KIND_ERR) pend_d = STAT_REJ;
            else pend_d = busy_d ? STAT_BUSY : STAT_NOCARD;
          end
        end
      end
    endcase

    if (phase_d != PH_IDLE) begin
      res_d.tx_valid = 1'b1;
      res_d.tx_byte  = BYTE_FF;
      res_d.select_low = !(phase_d == PH_WAKE || phase_d == PH_DESEL ||
                           phase_d == PH_FAILDES || phase_d == PH_FINAL);
      if (phase_d == PH_FRAME) begin
        unique case (idx_d)
          10'd0: res_d.tx_byte = {2'b01, cmd_d};
          10'd1: res_d.tx_byte = arg_d[31:24];
          10'd2: res_d.tx_byte = arg_d[23:16];
          10'd3: res_d.tx_byte = arg_d[15:8];
          10'd4: res_d.tx_byte = arg_d[7:0];
          10'd5: res_d.tx_byte = (cmd_d == 6'd0) ? 8'h95 :
                                 ((cmd_d == 6'd8) ? 8'h87 : 8'h01);
          default: res_d.tx_byte = BYTE_FF;
        endcase
      end
    end
    res_d.done_res = done;
    res_d.status = done ? pend_d : '0;
    res_d.card_kind = kind_d;
    res_d.last_response = resp_d;
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_to_q <= 24'hFFFFFF; token_to_q <= 16'hFFFF; resp_rt_q <= 8'd31;
      idle_rt_q <= 8'd20; opc_rt_q <= 16'hFFFE;
      phase_q <= PH_IDLE; step_q <= ST_CMD0; poll_q <= '0; retry_q <= '0;
      idx_q <= '0; cmd_q <= '0; arg_q <= '0; trail_q <= '0; left_q <= '0;
      resp_q <= BYTE_FF; kind_q <= KIND_NONE; pend_q <= STAT_OK; busy_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_READY_TO: ready_to_q <= cfg_data_i;
          REG_TOKEN_TO: token_to_q <= cfg_data_i[15:0];
          REG_RESP_RT:  resp_rt_q  <= cfg_data_i[7:0];
          REG_IDLE_RT:  idle_rt_q  <= cfg_data_i[7:0];
          REG_OPC_RT:   opc_rt_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (take) begin
        phase_q <= phase_d; step_q <= step_d; poll_q <= poll_d; retry_q <= retry_d;
        idx_q <= idx_d; cmd_q <= cmd_d; arg_q <= arg_d; trail_q <= trail_d;
        left_q <= left_d; resp_q <= resp_d; kind_q <= kind_d; pend_q <= pend_d;
        busy_q <= busy_d;
      end
      if (take) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end
endmodule

/* rtl/core/sdsq_checker.sv */
// Port-level checks for the sequencer, bound onto the top level.
// Depends only on the top-level ports.
module sdsq_assert (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_last_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[18])
    else $error("block end without data");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[19] |-> !m_axis_tdata[8])
    else $error("done with a byte to send");
  a_sel_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[8])
    else $error("select without exchange");
endmodule

bind sd_spi_init_and_read_sequencer sdsq_assert u_sdsq_checker (.*);
